@@ rtl/src_pkg.sv @@
package src_pkg;

    // Default longest run of results kept for one frame
    localparam int MAX_RUN_DEF = 64;

    // Field and datapath widths
    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 21;
    localparam int TAIL_W   = 6;
    localparam int IDX_W    = 3;
    localparam int WEIGHT_W = 17;
    localparam int DIFF_W   = 17;
    localparam int ACC_W    = 33;
    localparam int PROD_W   = DIFF_W + WEIGHT_W + 1;

    // Step limits, full weight and tail limit
    localparam logic [STEP_W-1:0]   STEP_MIN    = 21'd2048;
    localparam logic [STEP_W-1:0]   STEP_MAX    = 21'd1048576;
    localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 17'd65536;
    localparam logic [TAIL_W-1:0]   TAIL_LIMIT  = 6'd32;

    // Conversion modes
    localparam logic [1:0] MODE_NEAREST = 2'd0;
    localparam logic [1:0] MODE_LINEAR  = 2'd1;
    localparam logic [1:0] MODE_BOX     = 2'd2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [IDX_W-1:0] REG_STEP      = 3'd1;
    localparam logic [IDX_W-1:0] REG_IN_WIDE   = 3'd2;
    localparam logic [IDX_W-1:0] REG_OUT_WIDE  = 3'd3;
    localparam logic [IDX_W-1:0] REG_TWO_CH    = 3'd4;
    localparam logic [IDX_W-1:0] REG_TAIL      = 3'd5;

    // Lane operations
    typedef logic [2:0] t_lane_op;
    localparam t_lane_op OP_NOP      = 3'd0;
    localparam t_lane_op OP_EMIT     = 3'd1;  // (base << 16) + diff * weight, emit
    localparam t_lane_op OP_ACC_EMIT = 3'd2;  // sum += diff * weight, emit sum
    localparam t_lane_op OP_ACC_ADD  = 3'd3;  // sum += diff * weight
    localparam t_lane_op OP_ACC_LOAD = 3'd4;  // sum  = diff * weight

    // Sample format shared by the lanes
    typedef struct packed {
        logic in_wide;
        logic out_wide;
    } t_fmt;

    // Command issued to both lanes each cycle
    typedef struct packed {
        t_lane_op            op;
        logic [WEIGHT_W-1:0] weight;
        logic                run_end;
    } t_lane_ctl;

    // Result leaving a lane
    typedef struct packed {
        logic                emit;
        logic                run_end;
        logic [SAMPLE_W-1:0] sample;
    } t_lane_res;

endpackage

@@ rtl/src_lane.sv @@
module src_lane (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_en,
    input  logic                                     i_clear,
    input  src_pkg::t_fmt                            i_fmt,
    input  src_pkg::t_lane_ctl                       i_ctl,
    input  logic signed [src_pkg::SAMPLE_W-1:0]      i_base,
    input  logic signed [src_pkg::DIFF_W-1:0]        i_diff,
    output src_pkg::t_lane_res                       o_res
);

    logic signed [src_pkg::PROD_W-1:0]   prod_full;
    logic signed [src_pkg::ACC_W-1:0]    base_ext;
    logic signed [src_pkg::ACC_W-1:0]    sum_in;
    logic signed [src_pkg::ACC_W-1:0]    weighted;
    logic signed [src_pkg::ACC_W-1:0]    shifted;
    logic signed [src_pkg::ACC_W-1:0]    sat_hi;
    logic signed [src_pkg::ACC_W-1:0]    sat_lo;
    logic signed [src_pkg::ACC_W-1:0]    sat;

    src_pkg::t_lane_op                   r_op;
    logic                                r_run_end;
    logic signed [src_pkg::SAMPLE_W-1:0] r_base;
    logic signed [src_pkg::ACC_W-1:0]    r_prod;
    logic signed [src_pkg::ACC_W-1:0]    r_sum;

    // Multiply stage: signed difference times unsigned weight
    assign prod_full = i_diff * $signed({1'b0, i_ctl.weight});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= src_pkg::OP_NOP;
        end else if (i_clear) begin
            r_op <= src_pkg::OP_NOP;
        end else if (i_en) begin
            r_op <= i_ctl.op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod    <= prod_full[src_pkg::ACC_W-1:0];
            r_base    <= i_base;
            r_run_end <= i_ctl.run_end;
        end
    end

    // Sum stage
    assign base_ext = {r_base[src_pkg::SAMPLE_W-1], r_base, 16'h0000};
    assign sum_in   = r_sum + r_prod;

    always_comb begin
        if (r_op == src_pkg::OP_EMIT) begin
            weighted = base_ext + r_prod;
        end else begin
            weighted = sum_in;
        end
    end

    // Box accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_clear) begin
            r_sum <= '0;
        end else if (i_en) begin
            unique case (r_op)
                src_pkg::OP_ACC_EMIT,
                src_pkg::OP_ACC_ADD:  r_sum <= sum_in;
                src_pkg::OP_ACC_LOAD: r_sum <= r_prod;
                default:              r_sum <= r_sum;
            endcase
        end
    end

    // Width conversion: drop the weight and rescale, then saturate
    always_comb begin
        unique case ({i_fmt.in_wide, i_fmt.out_wide})
            2'b01:   shifted = weighted >>> 8;
            2'b10:   shifted = weighted >>> 24;
            default: shifted = weighted >>> 16;
        endcase
        sat_hi = i_fmt.out_wide ? 33'sd32767 : 33'sd127;
        sat_lo = i_fmt.out_wide ? -33'sd32768 : -33'sd128;
        if (shifted > sat_hi) begin
            sat = sat_hi;
        end else if (shifted < sat_lo) begin
            sat = sat_lo;
        end else begin
            sat = shifted;
        end
    end

    assign o_res.emit    = (r_op == src_pkg::OP_EMIT) || (r_op == src_pkg::OP_ACC_EMIT);
    assign o_res.run_end = r_run_end;
    assign o_res.sample  = sat[src_pkg::SAMPLE_W-1:0];

endmodule

@@ rtl/src_merge.sv @@
module src_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  src_pkg::t_lane_res   i_left,
    input  src_pkg::t_lane_res   i_right,
    input  logic                 i_ready,
    output logic                 o_en,
    output logic                 o_valid,
    output logic [31:0]          o_data,   // left_out [15:0], right_out [31:16]
    output logic                 o_last
);

    logic        r_valid;
    logic [31:0] r_data;
    logic        r_last;

    // Pipeline moves whenever the output register is free or being emptied
    assign o_en = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_left.emit && i_right.emit;
        end
    end

    // Join the two lane samples into one beat
    always_ff @(posedge i_clk) begin
        if (o_en && i_left.emit) begin
            r_data <= {i_right.sample, i_left.sample};
            r_last <= i_left.run_end;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

@@ rtl/pcm_sample_rate_converter.sv @@
// Channel   Dir  Beat contents
// s_axis    in   tdata: left_sample [15:0], right_sample [31:16]; tlast: final_frame
// m_axis    out  tdata: left_out [15:0], right_out [31:16]; tlast: run_end
// cfg       in   i_cfg_we / i_cfg_index / i_cfg_data, one register per write
//
// A frame has an accept step, then one emit loop step per phase step (up to 32) plus
// one per tail copy in linear mode; a skipped frame takes one step, box mode one or two.
// Results pass through the lane register and then the output register of src_merge.
// Synchronous active-low reset; no clearing pass. A stalled output freezes the
// sequencer and both lanes; the next frame is taken while results still drain.
module pcm_sample_rate_converter #(
    parameter int MAX_RUN = src_pkg::MAX_RUN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,   // left_sample, right_sample
    input  logic                              s_axis_tlast,   // final_frame
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,   // left_out, right_out
    output logic                              m_axis_tlast,   // run_end
    input  logic                              i_cfg_we,
    input  logic [src_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [src_pkg::STEP_W-1:0]        i_cfg_data
);

    localparam int CW = $clog2(MAX_RUN + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_TAIL = 2'd2;
    localparam logic [1:0] S_ACC2 = 2'd3;

    // Configuration registers
    logic [1:0]                  r_mode;
    logic [src_pkg::STEP_W-1:0]  r_step;
    logic                        r_in_wide;
    logic                        r_out_wide;
    logic                        r_two_ch;
    logic [src_pkg::TAIL_W-1:0]  r_tail;

    // Sequencer state
    logic [1:0]                           r_state,     n_state;
    logic [15:0]                          r_phase,     n_phase;
    logic [4:0]                           r_skip,      n_skip;
    logic                                 r_have_prev, n_have_prev;
    logic signed [src_pkg::SAMPLE_W-1:0]  r_prev_l,    n_prev_l;
    logic signed [src_pkg::SAMPLE_W-1:0]  r_prev_r,    n_prev_r;
    logic [CW-1:0]                        r_count,     n_count;
    logic [src_pkg::TAIL_W-1:0]           r_tail_left, n_tail_left;
    logic [src_pkg::WEIGHT_W-1:0]         r_pend_w,    n_pend_w;
    logic signed [src_pkg::SAMPLE_W-1:0]  r_xl;
    logic signed [src_pkg::SAMPLE_W-1:0]  r_xr;
    logic                                 r_final;

    logic                                 in_accept;
    logic                                 cfg_hit;
    logic                                 en;
    logic                                 is_box;
    logic                                 is_lin;
    logic [src_pkg::STEP_W-1:0]           step_c;
    logic [src_pkg::WEIGHT_W-1:0]         s2;
    logic [src_pkg::WEIGHT_W-1:0]         box_acc;
    logic [src_pkg::STEP_W-1:0]           lin_acc;
    logic                                 moved;
    logic [src_pkg::TAIL_W-1:0]           tail_n;
    logic                                 tail_follows;
    logic                                 room;
    logic                                 count_last;
    logic                                 post_loop;
    logic                                 frame_done;
    logic signed [src_pkg::SAMPLE_W-1:0]  in_l;
    logic signed [src_pkg::SAMPLE_W-1:0]  in_r;
    logic signed [src_pkg::DIFF_W-1:0]    xl_ext;
    logic signed [src_pkg::DIFF_W-1:0]    xr_ext;

    src_pkg::t_fmt                        fmt;
    src_pkg::t_lane_ctl                   ctl;
    logic signed [src_pkg::SAMPLE_W-1:0]  base_l, base_r;
    logic signed [src_pkg::DIFF_W-1:0]    diff_l, diff_r;
    src_pkg::t_lane_res                   res_l, res_r;

    // Configuration port
    assign cfg_hit = i_cfg_we && (i_cfg_index <= src_pkg::REG_TAIL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= src_pkg::MODE_NEAREST;
            r_step     <= 21'd65536;
            r_in_wide  <= 1'b1;
            r_out_wide <= 1'b1;
            r_two_ch   <= 1'b0;
            r_tail     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                src_pkg::REG_MODE:     r_mode     <= i_cfg_data[1:0];
                src_pkg::REG_STEP:     r_step     <= i_cfg_data;
                src_pkg::REG_IN_WIDE:  r_in_wide  <= i_cfg_data[0];
                src_pkg::REG_OUT_WIDE: r_out_wide <= i_cfg_data[0];
                src_pkg::REG_TWO_CH:   r_two_ch   <= i_cfg_data[0];
                src_pkg::REG_TAIL:     r_tail     <= i_cfg_data[src_pkg::TAIL_W-1:0];
                default: ;
            endcase
        end
    end

    assign fmt.in_wide  = r_in_wide;
    assign fmt.out_wide = r_out_wide;

    // Input side; nothing is taken while reset is held
    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign in_l = r_in_wide ? s_axis_tdata[15:0]
                            : {{8{s_axis_tdata[7]}}, s_axis_tdata[7:0]};
    assign in_r = !r_two_ch ? 16'sd0
                : r_in_wide ? s_axis_tdata[31:16]
                            : {{8{s_axis_tdata[23]}}, s_axis_tdata[23:16]};

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_xl    <= in_l;
            r_xr    <= in_r;
            r_final <= s_axis_tlast;
        end
    end

    // Phase arithmetic
    assign is_box = (r_mode == src_pkg::MODE_BOX);
    assign is_lin = (r_mode == src_pkg::MODE_LINEAR);

    assign step_c = (r_step < src_pkg::STEP_MIN) ? src_pkg::STEP_MIN
                  : (r_step > src_pkg::STEP_MAX) ? src_pkg::STEP_MAX : r_step;
    assign s2      = (step_c > {4'b0, src_pkg::FULL_WEIGHT}) ? src_pkg::FULL_WEIGHT
                                                              : step_c[src_pkg::WEIGHT_W-1:0];
    assign box_acc = {1'b0, r_phase} + s2;
    assign lin_acc = {5'b0, r_phase} + step_c;
    assign moved   = (lin_acc[20:16] != 5'd0);

    assign tail_n       = (r_tail > src_pkg::TAIL_LIMIT) ? src_pkg::TAIL_LIMIT : r_tail;
    assign tail_follows = is_lin && r_final && (tail_n != '0);
    assign room         = (r_count < CW'(MAX_RUN));
    assign count_last   = (r_count == CW'(MAX_RUN - 1));

    assign xl_ext = {r_xl[src_pkg::SAMPLE_W-1], r_xl};
    assign xr_ext = {r_xr[src_pkg::SAMPLE_W-1], r_xr};

    // Sequencer: one loop step per enabled cycle
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_skip      = r_skip;
        n_have_prev = r_have_prev;
        n_prev_l    = r_prev_l;
        n_prev_r    = r_prev_r;
        n_count     = r_count;
        n_tail_left = r_tail_left;
        n_pend_w    = r_pend_w;
        ctl.op      = src_pkg::OP_NOP;
        ctl.weight  = '0;
        ctl.run_end = 1'b0;
        base_l      = r_xl;
        base_r      = r_xr;
        diff_l      = '0;
        diff_r      = '0;
        post_loop   = 1'b0;
        frame_done  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_RUN;
                    n_count = '0;
                end
            end
            S_RUN: begin
                if (en) begin
                    if (is_box) begin
                        diff_l = xl_ext;
                        diff_r = xr_ext;
                        if (r_final) begin
                            // close the open period with the remaining weight
                            ctl.op      = src_pkg::OP_ACC_EMIT;
                            ctl.weight  = src_pkg::FULL_WEIGHT - {1'b0, r_phase};
                            ctl.run_end = 1'b1;
                            n_pend_w    = '0;
                            n_state     = S_ACC2;
                            frame_done  = 1'b1;
                        end else if (box_acc[16]) begin
                            // period ends inside this frame: split the weight
                            ctl.op      = src_pkg::OP_ACC_EMIT;
                            ctl.weight  = s2 - {1'b0, box_acc[15:0]};
                            ctl.run_end = 1'b1;
                            n_pend_w    = {1'b0, box_acc[15:0]};
                            n_phase     = box_acc[15:0];
                            n_state     = S_ACC2;
                        end else begin
                            ctl.op     = src_pkg::OP_ACC_ADD;
                            ctl.weight = s2;
                            n_phase    = box_acc[15:0];
                            n_state    = S_IDLE;
                        end
                    end else if (r_skip != 5'd0) begin
                        n_skip    = r_skip - 5'd1;
                        post_loop = 1'b1;
                    end else if (!is_lin || r_have_prev) begin
                        if (room) begin
                            ctl.op  = src_pkg::OP_EMIT;
                            n_count = r_count + CW'(1);
                        end
                        if (is_lin) begin
                            ctl.weight = {1'b0, r_phase};
                            base_l     = r_prev_l;
                            base_r     = r_prev_r;
                            diff_l     = xl_ext - {r_prev_l[src_pkg::SAMPLE_W-1], r_prev_l};
                            diff_r     = xr_ext - {r_prev_r[src_pkg::SAMPLE_W-1], r_prev_r};
                        end
                        ctl.run_end = count_last || (moved && !tail_follows);
                        n_phase     = lin_acc[15:0];
                        if (moved) begin
                            n_skip    = lin_acc[20:16] - 5'd1;
                            post_loop = 1'b1;
                        end
                    end else begin
                        post_loop = 1'b1;
                    end

                    // end of the emit loop for this frame
                    if (post_loop) begin
                        if (is_lin) begin
                            n_prev_l    = r_xl;
                            n_prev_r    = r_xr;
                            n_have_prev = 1'b1;
                        end
                        if (tail_follows) begin
                            n_tail_left = tail_n;
                            n_state     = S_TAIL;
                        end else begin
                            n_state = S_IDLE;
                        end
                        frame_done = r_final;
                    end
                end
            end
            S_TAIL: begin
                if (en) begin
                    if (room) begin
                        ctl.op  = src_pkg::OP_EMIT;
                        n_count = r_count + CW'(1);
                    end
                    ctl.run_end = (r_tail_left == 6'd1) || count_last;
                    n_tail_left = r_tail_left - 6'd1;
                    if (r_tail_left == 6'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ACC2: begin
                if (en) begin
                    ctl.op     = src_pkg::OP_ACC_LOAD;
                    ctl.weight = r_pend_w;
                    diff_l     = xl_ext;
                    diff_r     = xr_ext;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // run state back to zero after a final frame or a register write
        if (frame_done || cfg_hit) begin
            n_phase     = '0;
            n_skip      = '0;
            n_have_prev = 1'b0;
            n_prev_l    = '0;
            n_prev_r    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_skip      <= '0;
            r_have_prev <= 1'b0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_count     <= '0;
            r_tail_left <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_skip      <= n_skip;
            r_have_prev <= n_have_prev;
            r_prev_l    <= n_prev_l;
            r_prev_r    <= n_prev_r;
            r_count     <= n_count;
            r_tail_left <= n_tail_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_w <= n_pend_w;
    end

    // Left and right lanes
    src_lane u_lane_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_clear (cfg_hit),
        .i_fmt   (fmt),
        .i_ctl   (ctl),
        .i_base  (base_l),
        .i_diff  (diff_l),
        .o_res   (res_l)
    );

    src_lane u_lane_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_clear (cfg_hit),
        .i_fmt   (fmt),
        .i_ctl   (ctl),
        .i_base  (base_r),
        .i_diff  (diff_r),
        .o_res   (res_r)
    );

    // Output register joining the lanes
    src_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_left  (res_l),
        .i_right (res_r),
        .i_ready (m_axis_tready),
        .o_en    (en),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

    // Checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_l.emit == res_r.emit) && (res_l.run_end == res_r.run_end))
        else $error("lanes out of step");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RUN))
        else $error("run count beyond limit");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_RUN))
        else $error("accepted frame not started");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAIL) |-> (is_lin && (r_tail_left != '0)))
        else $error("tail run outside linear mode");

endmodule

@@ test/pcm_sample_rate_converter_tb.sv @@
module pcm_sample_rate_converter_tb;

    localparam int          IDX_W         = src_pkg::IDX_W;
    localparam int          STEP_W        = src_pkg::STEP_W;
    localparam int          TAIL_W        = src_pkg::TAIL_W;
    localparam int          RUN_LIMIT     = src_pkg::MAX_RUN_DEF;
    localparam int          RANDOM_FRAMES = 184;
    localparam int          SETTLE_CYCLES = 100;
    localparam int          CYCLE_LIMIT   = 2000000;
    // mode code that the block does not define; must act as nearest pick
    localparam logic [1:0]  MODE_SPARE    = 2'd3;
    // register index with no register behind it
    localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

    // one output beat as the checker sees it
    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        run_end;
    } t_pcm_beat;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [31:0]         m_axis_tdata;
    logic                m_axis_tlast;
    logic                i_cfg_we = 1'b0;
    logic [IDX_W-1:0]    i_cfg_index = '0;
    logic [STEP_W-1:0]   i_cfg_data = '0;

    // register copies, reset values of the block
    logic [1:0]          cfg_mode = src_pkg::MODE_NEAREST;
    logic [STEP_W-1:0]   cfg_step = 21'd65536;
    logic                cfg_in_wide = 1'b1;
    logic                cfg_out_wide = 1'b1;
    logic                cfg_two_ch = 1'b0;
    logic [TAIL_W-1:0]   cfg_tail = '0;

    // run state of the converter
    logic [15:0]         phase_frac = '0;
    logic [4:0]          skip_frames = '0;
    bit                  prev_valid = 1'b0;
    int                  prev_left = 0;
    int                  prev_right = 0;
    longint              box_sum_left = 0;
    longint              box_sum_right = 0;

    t_pcm_beat           pending_beats[$];
    t_pcm_beat           frame_out[$];

    // idling controls
    int                  max_gap = 0;
    int                  burst_left = 0;
    bit                  stall_enable = 1'b0;
    logic [7:0]          ready_pattern = 8'hFF;
    logic [2:0]          stall_slot = '0;

    int                  cycle_count = 0;
    int                  mismatch_count = 0;
    int                  beats_checked = 0;
    int                  frames_sent = 0;
    int                  settings_used = 0;
    int                  random_frames = 0;

    pcm_sample_rate_converter #(
        .MAX_RUN(RUN_LIMIT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Converter prediction
    // ------------------------------------------------------------------

    function automatic void clear_run();
        phase_frac    = '0;
        skip_frames   = '0;
        prev_valid    = 1'b0;
        prev_left     = 0;
        prev_right    = 0;
        box_sum_left  = 0;
        box_sum_right = 0;
    endfunction

    // weighted sum (full weight 65536) to an output sample, with width shift
    function automatic logic [15:0] scale_to_output(longint weighted);
        int     sh;
        longint lim;
        longint r;
        sh = 16;
        if (!cfg_in_wide && cfg_out_wide) sh = 8;
        if (cfg_in_wide && !cfg_out_wide) sh = 24;
        lim = cfg_out_wide ? 32767 : 127;
        r = weighted >>> sh;
        if (r > lim) r = lim;
        if (r < -lim - 1) r = -lim - 1;
        return r[15:0];
    endfunction

    function automatic logic [15:0] blend(int a, int b, logic [15:0] f);
        longint wf;
        wf = longint'(f);
        return scale_to_output((longint'(src_pkg::FULL_WEIGHT) - wf) * a + wf * b);
    endfunction

    function automatic logic [15:0] hold_sample(int x);
        return scale_to_output(longint'(x) * longint'(src_pkg::FULL_WEIGHT));
    endfunction

    // runs past the limit are dropped
    function automatic void emit_beat(logic [15:0] l, logic [15:0] r);
        if (frame_out.size() < RUN_LIMIT)
            frame_out.push_back('{left: l, right: r, run_end: 1'b0});
    endfunction

    // one output step of the phase; 1 when the input pointer moves on
    function automatic bit advance_phase(int unsigned step);
        logic [31:0] acc;
        logic [15:0] adv;
        acc = 32'(phase_frac) + 32'(step);
        adv = acc[31:16];
        phase_frac = acc[15:0];
        if (adv == 0) return 1'b0;
        skip_frames = 5'(adv - 16'd1);
        return 1'b1;
    endfunction

    task automatic predict_frame(input logic [15:0] l_in, input logic [15:0] r_in,
                                 input logic last);
        int          xl;
        int          xr;
        int unsigned step;
        int unsigned box_step;
        int unsigned tail_count;
        logic [31:0] acc;
        longint      w;
        if (cfg_in_wide) begin
            xl = int'($signed(l_in));
            xr = int'($signed(r_in));
        end else begin
            xl = int'($signed(l_in[7:0]));
            xr = int'($signed(r_in[7:0]));
        end
        if (!cfg_two_ch) xr = 0;
        step = cfg_step;
        if (step < src_pkg::STEP_MIN) step = src_pkg::STEP_MIN;
        if (step > src_pkg::STEP_MAX) step = src_pkg::STEP_MAX;
        frame_out.delete();

        case (cfg_mode)
            src_pkg::MODE_BOX: begin
                box_step = (step > src_pkg::FULL_WEIGHT) ? src_pkg::FULL_WEIGHT : step;
                if (last) begin
                    // close the open output with what is left of its period
                    w = longint'(src_pkg::FULL_WEIGHT) - longint'(phase_frac);
                    box_sum_left  += w * xl;
                    box_sum_right += w * xr;
                    emit_beat(scale_to_output(box_sum_left), scale_to_output(box_sum_right));
                end else begin
                    acc = 32'(phase_frac) + 32'(box_step);
                    if (acc >= 32'(src_pkg::FULL_WEIGHT)) begin
                        acc -= 32'(src_pkg::FULL_WEIGHT);
                        w = longint'(box_step) - longint'(acc);
                        box_sum_left  += w * xl;
                        box_sum_right += w * xr;
                        emit_beat(scale_to_output(box_sum_left),
                                  scale_to_output(box_sum_right));
                        box_sum_left  = longint'(acc) * xl;
                        box_sum_right = longint'(acc) * xr;
                    end else begin
                        box_sum_left  += longint'(box_step) * xl;
                        box_sum_right += longint'(box_step) * xr;
                    end
                    phase_frac = acc[15:0];
                end
            end
            src_pkg::MODE_LINEAR: begin
                if (skip_frames > 0) begin
                    skip_frames--;
                end else if (prev_valid) begin
                    do begin
                        emit_beat(blend(prev_left, xl, phase_frac),
                                  blend(prev_right, xr, phase_frac));
                    end while (!advance_phase(step));
                end
                // skipped frames still become the previous sample
                prev_left  = xl;
                prev_right = xr;
                prev_valid = 1'b1;
                if (last) begin
                    tail_count = (cfg_tail > src_pkg::TAIL_LIMIT) ? src_pkg::TAIL_LIMIT
                                                                  : cfg_tail;
                    repeat (tail_count) emit_beat(hold_sample(xl), hold_sample(xr));
                end
            end
            default: begin
                if (skip_frames > 0) begin
                    skip_frames--;
                end else begin
                    do begin
                        emit_beat(hold_sample(xl), hold_sample(xr));
                    end while (!advance_phase(step));
                end
            end
        endcase

        if (last) clear_run();
        if (frame_out.size() > 0) frame_out[frame_out.size() - 1].run_end = 1'b1;
        foreach (frame_out[i]) pending_beats.push_back(frame_out[i]);
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // one input beat; the sender runs in bursts with random gaps after them
    task automatic send_frame(input logic [15:0] l_in, input logic [15:0] r_in,
                              input logic last);
        int gap;
        s_axis_tdata  <= {r_in, l_in};
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predict_frame(l_in, r_in, last);
        frames_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 7);
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // wait until every expected beat is out and the sequencer has settled
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [STEP_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        case (idx)
            src_pkg::REG_MODE:     cfg_mode     = value[1:0];
            src_pkg::REG_STEP:     cfg_step     = value;
            src_pkg::REG_IN_WIDE:  cfg_in_wide  = value[0];
            src_pkg::REG_OUT_WIDE: cfg_out_wide = value[0];
            src_pkg::REG_TWO_CH:   cfg_two_ch   = value[0];
            src_pkg::REG_TAIL:     cfg_tail     = value[TAIL_W-1:0];
            default:               return;
        endcase
        clear_run();
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [STEP_W-1:0] step,
                              input logic in_wide, input logic out_wide,
                              input logic two_ch, input logic [TAIL_W-1:0] tail);
        drain_results();
        write_reg(src_pkg::REG_MODE, STEP_W'(mode));
        write_reg(src_pkg::REG_STEP, step);
        write_reg(src_pkg::REG_IN_WIDE, STEP_W'(in_wide));
        write_reg(src_pkg::REG_OUT_WIDE, STEP_W'(out_wide));
        write_reg(src_pkg::REG_TWO_CH, STEP_W'(two_ch));
        write_reg(src_pkg::REG_TAIL, STEP_W'(tail));
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Random choices
    // ------------------------------------------------------------------

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h007F;
            3:       return 16'hFF80;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] pick_step(logic [1:0] mode);
        case ($urandom_range(0, 9))
            0: return STEP_W'($urandom_range(0, int'(src_pkg::STEP_MIN) - 1));
            1: return src_pkg::STEP_MIN;
            2: return STEP_W'($urandom_range(int'(src_pkg::STEP_MAX), 2**STEP_W - 1));
            3: return src_pkg::STEP_MAX;
            default: begin
                if (mode == src_pkg::MODE_LINEAR) return STEP_W'($urandom_range(4096, 98304));
                if (mode == src_pkg::MODE_BOX) return STEP_W'($urandom_range(4096, 65536));
                return STEP_W'($urandom_range(8192, 262144));
            end
        endcase
    endfunction

    function automatic logic [TAIL_W-1:0] pick_tail();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return src_pkg::TAIL_LIMIT;
            2:       return '1;
            default: return TAIL_W'($urandom_range(0, 2**TAIL_W - 1));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset settings: nearest, unit step, 16 bit in and out, mono
    task automatic test_reset_defaults();
        max_gap      = 0;
        stall_enable = 1'b0;
        send_frame(16'h7FFF, 16'h1234, 1'b0);
        send_frame(16'h8000, 16'h0000, 1'b0);
        send_frame(16'h0001, 16'hFFFF, 1'b0);
        send_frame(16'hFFFF, 16'h0000, 1'b1);
    endtask

    // step below the floor and above the ceiling, narrow inputs out of range
    task automatic test_nearest_steps();
        max_gap      = 4;
        stall_enable = 1'b1;
        set_config(src_pkg::MODE_NEAREST, '0, 1'b0, 1'b1, 1'b1, '0);
        send_frame(16'hFF80, 16'h017F, 1'b0);
        send_frame(16'h0080, 16'hFF7F, 1'b1);
        set_config(MODE_SPARE, '1, 1'b1, 1'b0, 1'b0, '0);
        send_frame(16'h7FFF, 16'h0000, 1'b0);
        send_frame(16'h8000, 16'h0000, 1'b0);
        send_frame(16'h00FF, 16'h0000, 1'b0);
        send_frame(16'hFF00, 16'h0000, 1'b1);
    endtask

    // first frame gives nothing, tails from clamped to full, skip path
    task automatic test_linear_upsample();
        set_config(src_pkg::MODE_LINEAR, 21'd16384, 1'b1, 1'b1, 1'b1, '1);
        send_frame(16'h7FFF, 16'h8000, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b0);
        send_frame(16'h0000, 16'h1234, 1'b1);
        // longest run: 32 interpolated beats plus a 32 beat tail
        set_config(src_pkg::MODE_LINEAR, src_pkg::STEP_MIN, 1'b0, 1'b0, 1'b1,
                   src_pkg::TAIL_LIMIT);
        send_frame(16'h007F, 16'h0080, 1'b0);
        send_frame(16'h0080, 16'h007F, 1'b1);
        set_config(src_pkg::MODE_LINEAR, 21'd196608, 1'b1, 1'b1, 1'b0, 6'd1);
        send_frame(16'h4000, 16'h0000, 1'b0);
        send_frame(16'hC000, 16'h0000, 1'b0);
        send_frame(16'h2000, 16'h0000, 1'b0);
        send_frame(16'hE000, 16'h0000, 1'b1);
    endtask

    // step above full weight acts as full; final frame closes the open output
    task automatic test_box_downsample();
        set_config(src_pkg::MODE_BOX, '1, 1'b1, 1'b0, 1'b1, '0);
        send_frame(16'h7FFF, 16'h8000, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b1);
        set_config(src_pkg::MODE_BOX, 21'd24576, 1'b0, 1'b1, 1'b0, '0);
        send_frame(16'h007F, 16'h0000, 1'b0);
        send_frame(16'hFF80, 16'h0000, 1'b0);
        send_frame(16'h0055, 16'h0000, 1'b1);
    endtask

    // a write to an index with no register keeps the phase of the run
    task automatic test_unused_index();
        set_config(src_pkg::MODE_NEAREST, 21'h18000, 1'b1, 1'b1, 1'b0, '0);
        send_frame(16'h1111, 16'h0000, 1'b0);
        drain_results();
        write_reg(REG_NONE, '1);
        send_frame(16'h2222, 16'h0000, 1'b1);
    endtask

    // sounds of random content; a few end without a final frame
    task automatic test_random_sounds();
        logic [1:0] mode;
        int         n_frames;
        bit         unfinished;
        logic       last;
        while (random_frames < RANDOM_FRAMES) begin
            max_gap      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            stall_enable = ($urandom_range(0, 3) != 0);
            if (random_frames == 0 || $urandom_range(0, 4) != 0) begin
                mode = 2'($urandom_range(0, 3));
                set_config(mode, pick_step(mode), 1'($urandom), 1'($urandom),
                           1'($urandom), pick_tail());
            end
            n_frames   = $urandom_range(1, 12);
            unfinished = ($urandom_range(0, 5) == 0);
            for (int i = 0; i < n_frames; i++) begin
                last = (i == n_frames - 1) && !unfinished;
                send_frame(pick_sample(), pick_sample(), last);
                random_frames++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver stalls: ready follows an 8-bit pattern, some windows fully open
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : receiver_stalls
        if (stall_slot == 3'd0)
            ready_pattern = (!stall_enable || $urandom_range(0, 3) == 0) ?
                            8'hFF : (8'($urandom) | 8'h01);
        m_axis_tready <= ready_pattern[stall_slot];
        stall_slot    <= stall_slot + 3'd1;
    end

    // ------------------------------------------------------------------
    // Output check against the oldest expected beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_beats
        t_pcm_beat want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            beats_checked++;
            if (pending_beats.size() == 0) begin
                $error("unexpected beat: left_out %0d right_out %0d run_end %0b",
                       $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                       m_axis_tlast);
                mismatch_count++;
            end else begin
                want = pending_beats.pop_front();
                if (m_axis_tdata[15:0] !== want.left) begin
                    $error("left_out: expected %0d, got %0d",
                           $signed(want.left), $signed(m_axis_tdata[15:0]));
                    mismatch_count++;
                end
                if (m_axis_tdata[31:16] !== want.right) begin
                    $error("right_out: expected %0d, got %0d",
                           $signed(want.right), $signed(m_axis_tdata[31:16]));
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.run_end) begin
                    $error("run_end: expected %0b, got %0b", want.run_end, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("timed out with %0d beats outstanding", pending_beats.size());
            $display("pcm_sample_rate_converter_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_nearest_steps();
        test_linear_upsample();
        test_box_downsample();
        test_unused_index();
        test_random_sounds();
        drain_results();
        $display("Sent %0d frames over %0d register settings; %0d output beats compared.",
                 frames_sent, settings_used, beats_checked);
        $display("Covered nearest, linear, box and the spare mode, clamped steps, tails,");
        $display("8/16 bit widths, mono and stereo, with sender gaps and receiver stalls.");
        if (mismatch_count == 0 && pending_beats.size() == 0) begin
            $display("pcm_sample_rate_converter_tb: PASS");
        end else begin
            $display("pcm_sample_rate_converter_tb: FAIL");
        end
        $finish;
    end

endmodule
